// ===== hw/rtl/wlda_pkg.sv =====
// Shared widths, opcodes and saturating helpers for the weighted LDA CVB0 update unit.
// No dependencies.
`timescale 1ns / 1ps

package wlda_pkg;

  localparam int unsigned TOPICS = 16;
  localparam int unsigned VOCAB = 4096;
  localparam int unsigned DOCS = 1024;
  localparam int unsigned TOKEN_SLOTS = 16384;

  localparam int unsigned OP_W = 3;
  localparam int unsigned TOPIC_W = $clog2(TOPICS);
  localparam int unsigned WORD_W = $clog2(VOCAB);
  localparam int unsigned DOC_W = $clog2(DOCS);
  localparam int unsigned SLOT_W = $clog2(TOKEN_SLOTS);
  localparam int unsigned VAL_W = 48;
  // exact row sum of TOPICS values of VAL_W bits
  localparam int unsigned SUM_W = VAL_W + TOPIC_W;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  localparam logic [OP_W-1:0] OP_WEIGHT = 3'd0;
  localparam logic [OP_W-1:0] OP_WORD_PRIOR = 3'd1;
  localparam logic [OP_W-1:0] OP_DOC_PRIOR = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_PHI = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_MAX = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_COUNT = 3'd6;

  function automatic logic [VAL_W-1:0] sub_floor(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    sub_floor = (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [VAL_W-1:0] add_clamp(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_clamp = s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/wlda_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on wlda_pkg.
`timescale 1ns / 1ps

interface wlda_req_if import wlda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [DOC_W-1:0]   doc_index;
  logic [SLOT_W-1:0]  token_slot;
  logic [WORD_W-1:0]  word_index;
  logic [TOPIC_W-1:0] topic_index;
  logic [VAL_W-1:0]   operand_value;

  modport source (output valid, opcode, doc_index, token_slot, word_index, topic_index,
                  operand_value, input ready);
  modport sink (input valid, opcode, doc_index, token_slot, word_index, topic_index,
                operand_value, output ready);
endinterface

interface wlda_rsp_if import wlda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] result_value;
  logic             divide_fault;

  modport source (output valid, result_value, divide_fault, input ready);
  modport sink (input valid, result_value, divide_fault, output ready);
endinterface

// ===== hw/rtl/weighted_lda_cvb0_token_update_unit.sv =====
// Weighted LDA CVB0 token update unit: count tables, responsibilities and the update sequencer.
// Depends on wlda_pkg and the channel interfaces in wlda_if.sv.
`timescale 1ns / 1ps

// One request is taken at a time and answered by exactly one response transfer.
// Loads and reads go via ST_SIMPLE or ST_RMW_RD/WR; the word prior fill loops in ST_FILL.
// A token update runs two passes over the TOPICS topics. In each pass every topic does one
// saturating division in a radix-2 bit-serial divider and one 48x48 multiply in a 48x16
// unit, plus memory reads and writes.
// The response register frees the request side as soon as the result is parked.
// Word-topic, doc-topic, responsibility and weight tables are single-port synchronous
// memories with no reset; topic totals and the sweep maximum reset to zero.
// A zero divisor saturates the quotient to all ones and raises divide_fault.
module weighted_lda_cvb0_token_update_unit import wlda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wlda_req_if.sink   req_i,
  wlda_rsp_if.source rsp_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SIMPLE = 4'd1;
  localparam logic [3:0] ST_FILL   = 4'd2;
  localparam logic [3:0] ST_RMW_RD = 4'd3;
  localparam logic [3:0] ST_RMW_WR = 4'd4;
  localparam logic [3:0] ST_P1_RD  = 4'd5;
  localparam logic [3:0] ST_P1_SUB = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_MUL    = 4'd8;
  localparam logic [3:0] ST_P1_ACC = 4'd9;
  localparam logic [3:0] ST_P2_BEG = 4'd10;
  localparam logic [3:0] ST_P2_DIV = 4'd11;
  localparam logic [3:0] ST_P2_WR  = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned LIMB_W = 16;
  localparam int unsigned LIMBS = VAL_W / LIMB_W;
  localparam int unsigned FRAC_W = 32;
  localparam logic [5:0] DIV_STEPS = 6'(VAL_W);

  // tables
  logic [VAL_W-1:0] wt_mem [VOCAB*TOPICS];
  logic [VAL_W-1:0] dt_mem [DOCS*TOPICS];
  logic [VAL_W-1:0] tr_mem [TOKEN_SLOTS*TOPICS];
  logic [VAL_W-1:0] ww_mem [VOCAB];
  logic [VAL_W-1:0] wt_rd_q, dt_rd_q, tr_rd_q, ww_rd_q;

  logic [VAL_W-1:0] tt_q [TOPICS];
  logic [VAL_W-1:0] tt_d;
  logic             tt_we;

  logic [VAL_W-1:0] old_q [TOPICS];
  logic [VAL_W-1:0] new_q [TOPICS];
  logic             old_we, new_we;
  logic [VAL_W-1:0] old_d, new_d;

  // latched request
  logic [OP_W-1:0]    op_q, op_d;
  logic [DOC_W-1:0]   doc_q, doc_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [TOPIC_W-1:0] k_q, k_d;

  logic [3:0] state_q, state_d;
  logic       nrm_q, nrm_d;   // 0: removal pass, 1: normalize pass

  // divider
  logic [SUM_W-1:0] den_q, den_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] num_q, num_d;
  logic [VAL_W-1:0] quo_q, quo_d;
  logic [5:0]       dcnt_q, dcnt_d;
  logic [SUM_W:0]   div_t;

  // multiplier
  logic [VAL_W-1:0]  ma_q, ma_d, mb_q, mb_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [1:0]        mstep_q, mstep_d;
  logic [63:0]       pp;

  logic [VAL_W-1:0] dc_q, dc_d;
  logic [SUM_W-1:0] rsum_q, rsum_d;
  logic [VAL_W-1:0] maxc_q, maxc_d;
  logic [VAL_W-1:0] smax_q, smax_d;
  logic [VAL_W-1:0] res_q, res_d;
  logic             flt_q, flt_d;

  logic             out_vld_q, out_vld_d;
  logic [VAL_W-1:0] out_res_q, out_res_d;
  logic             out_flt_q, out_flt_d;

  logic             wt_we, dt_we, tr_we, ww_we;
  logic [VAL_W-1:0] wt_wd, dt_wd, tr_wd;

  logic [WORD_W+TOPIC_W-1:0] wt_addr;
  logic [DOC_W+TOPIC_W-1:0]  dt_addr;
  logic [SLOT_W+TOPIC_W-1:0] tr_addr;

  logic [VAL_W-1:0] wc_s, dc_s, tt_s, phi, p, nv, diff;
  logic [PROD_W-1:0] dvd;
  logic [SUM_W-1:0]  dsr;
  logic              div_go;

  assign wt_addr = {word_q, k_q};
  assign dt_addr = {doc_q, k_q};
  assign tr_addr = {slot_q, k_q};

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.result_value = out_res_q;
  assign rsp_o.divide_fault = out_flt_q;

  // divider step and multiplier limb
  assign div_t = {rem_q, num_q[VAL_W-1]};
  assign pp    = 64'(ma_q) * 64'(mb_q[mstep_q*LIMB_W +: LIMB_W]);

  assign phi  = tr_rd_q;
  assign wc_s = sub_floor(wt_rd_q, phi);
  assign dc_s = sub_floor(dt_rd_q, phi);
  assign tt_s = sub_floor(tt_q[k_q], phi);
  assign p    = quo_q;
  assign nv   = (acc_q[PROD_W-1:VAL_W+FRAC_W] != '0) ? VAL_MAX : acc_q[VAL_W+FRAC_W-1:FRAC_W];
  assign diff = (old_q[k_q] > p) ? (old_q[k_q] - p) : (p - old_q[k_q]);

  always_comb begin
    state_d = state_q;
    nrm_d   = nrm_q;
    op_d = op_q; doc_d = doc_q; slot_d = slot_q; word_d = word_q; val_d = val_q; k_d = k_q;
    den_d = den_q; rem_d = rem_q; num_d = num_q; quo_d = quo_q; dcnt_d = dcnt_q;
    ma_d = ma_q; mb_d = mb_q; acc_d = acc_q; mstep_d = mstep_q;
    dc_d = dc_q; rsum_d = rsum_q; maxc_d = maxc_q; smax_d = smax_q;
    res_d = res_q; flt_d = flt_q;
    out_vld_d = out_vld_q; out_res_d = out_res_q; out_flt_d = out_flt_q;
    wt_we = 1'b0; dt_we = 1'b0; tr_we = 1'b0; ww_we = 1'b0; tt_we = 1'b0;
    old_we = 1'b0; new_we = 1'b0;
    wt_wd = val_q; dt_wd = val_q; tr_wd = val_q; tt_d = val_q;
    old_d = phi; new_d = nv;
    dvd = '0; dsr = '0; div_go = 1'b0;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d   = req_i.opcode;
          doc_d  = req_i.doc_index;
          slot_d = req_i.token_slot;
          word_d = req_i.word_index;
          val_d  = req_i.operand_value;
          k_d    = req_i.topic_index;
          res_d  = '0;
          flt_d  = 1'b0;
          nrm_d  = 1'b0;
          case (req_i.opcode)
            OP_WORD_PRIOR: begin
              k_d = '0;
              state_d = ST_FILL;
            end
            OP_LOAD_PHI, OP_READ_COUNT: state_d = ST_RMW_RD;
            OP_UPDATE: begin
              k_d = '0;
              rsum_d = '0;
              maxc_d = '0;
              state_d = ST_P1_RD;
            end
            default: state_d = ST_SIMPLE;
          endcase
        end
      end
      ST_SIMPLE: begin
        case (op_q)
          OP_WEIGHT: ww_we = 1'b1;
          OP_DOC_PRIOR: begin
            dt_we = 1'b1;
            tt_we = 1'b1;
            tt_d  = add_clamp(tt_q[k_q], val_q);
          end
          OP_READ_MAX: begin
            res_d  = smax_q;
            smax_d = '0;
          end
          default: ;
        endcase
        state_d = ST_DONE;
      end
      ST_FILL: begin
        wt_we = 1'b1;
        k_d   = k_q + 1'b1;
        if (k_q == TOPIC_W'(TOPICS - 1)) state_d = ST_DONE;
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: begin
        if (op_q == OP_LOAD_PHI) begin
          tr_we = 1'b1;
          wt_we = 1'b1;
          wt_wd = add_clamp(wt_rd_q, val_q);
          dt_we = 1'b1;
          dt_wd = add_clamp(dt_rd_q, val_q);
          tt_we = 1'b1;
          tt_d  = add_clamp(tt_q[k_q], val_q);
        end else begin
          res_d = wt_rd_q;
        end
        state_d = ST_DONE;
      end
      // removal pass
      ST_P1_RD: state_d = ST_P1_SUB;
      ST_P1_SUB: begin
        wt_we = 1'b1; wt_wd = wc_s;
        dt_we = 1'b1; dt_wd = dc_s;
        tt_we = 1'b1; tt_d  = tt_s;
        old_we = 1'b1;
        dc_d = dc_s;
        dvd = {{(PROD_W-VAL_W-FRAC_W){1'b0}}, wc_s, {FRAC_W{1'b0}}};
        dsr = SUM_W'(tt_s);
        div_go = 1'b1;
      end
      ST_DIV: begin
        if (dcnt_q == '0) begin
          if (nrm_q) begin
            state_d = ST_P2_WR;
          end else begin
            ma_d = quo_q;
            mb_d = dc_q;
            acc_d = '0;
            mstep_d = '0;
            state_d = ST_MUL;
          end
        end else begin
          if (div_t >= {1'b0, den_q}) begin
            rem_d = SUM_W'(div_t - {1'b0, den_q});
            quo_d = {quo_q[VAL_W-2:0], 1'b1};
          end else begin
            rem_d = div_t[SUM_W-1:0];
            quo_d = {quo_q[VAL_W-2:0], 1'b0};
          end
          num_d  = {num_q[VAL_W-2:0], 1'b0};
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      ST_MUL: begin
        case (mstep_q)
          2'd0: acc_d = acc_q + PROD_W'(pp);
          2'd1: acc_d = acc_q + (PROD_W'(pp) << LIMB_W);
          default: acc_d = acc_q + (PROD_W'(pp) << (2 * LIMB_W));
        endcase
        mstep_d = mstep_q + 1'b1;
        if (mstep_q == 2'(LIMBS - 1)) state_d = nrm_q ? ST_P2_DIV : ST_P1_ACC;
      end
      ST_P1_ACC: begin
        new_we = 1'b1;
        rsum_d = rsum_q + SUM_W'(nv);
        k_d = k_q + 1'b1;
        if (k_q == TOPIC_W'(TOPICS - 1)) begin
          nrm_d = 1'b1;
          state_d = ST_P2_BEG;
        end else begin
          state_d = ST_P1_RD;
        end
      end
      // normalize pass
      ST_P2_BEG: begin
        ma_d = new_q[k_q];
        mb_d = ww_rd_q;
        acc_d = '0;
        mstep_d = '0;
        state_d = ST_MUL;
      end
      ST_P2_DIV: begin
        dvd = acc_q;
        dsr = rsum_q;
        div_go = 1'b1;
      end
      ST_P2_WR: begin
        tr_we = 1'b1; tr_wd = p;
        wt_we = 1'b1; wt_wd = add_clamp(wt_rd_q, p);
        dt_we = 1'b1; dt_wd = add_clamp(dt_rd_q, p);
        tt_we = 1'b1; tt_d  = add_clamp(tt_q[k_q], p);
        if (diff > maxc_q) maxc_d = diff;
        k_d = k_q + 1'b1;
        if (k_q == TOPIC_W'(TOPICS - 1)) begin
          res_d = maxc_d;
          if (maxc_d > smax_q) smax_d = maxc_d;
          state_d = ST_DONE;
        end else begin
          state_d = ST_P2_BEG;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_res_d = res_q;
          out_flt_d = flt_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // divider launch: zero divisor and quotient overflow saturate at once
    if (div_go) begin
      den_d  = dsr;
      rem_d  = SUM_W'(dvd[PROD_W-1:VAL_W]);
      num_d  = dvd[VAL_W-1:0];
      quo_d  = '0;
      dcnt_d = DIV_STEPS;
      if (dsr == '0) begin
        flt_d  = 1'b1;
        quo_d  = VAL_MAX;
        dcnt_d = '0;
      end else if (SUM_W'(dvd[PROD_W-1:VAL_W]) >= dsr) begin
        quo_d  = VAL_MAX;
        dcnt_d = '0;
      end
      state_d = ST_DIV;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    wt_rd_q <= wt_mem[wt_addr];
    dt_rd_q <= dt_mem[dt_addr];
    tr_rd_q <= tr_mem[tr_addr];
    ww_rd_q <= ww_mem[word_q];
    if (wt_we) wt_mem[wt_addr] <= wt_wd;
    if (dt_we) dt_mem[dt_addr] <= dt_wd;
    if (tr_we) tr_mem[tr_addr] <= tr_wd;
    if (ww_we) ww_mem[word_q] <= val_q;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; doc_q <= doc_d; slot_q <= slot_d; word_q <= word_d; val_q <= val_d;
    k_q <= k_d;
    den_q <= den_d; rem_q <= rem_d; num_q <= num_d; quo_q <= quo_d;
    ma_q <= ma_d; mb_q <= mb_d; acc_q <= acc_d;
    dc_q <= dc_d; rsum_q <= rsum_d; maxc_q <= maxc_d; res_q <= res_d; flt_q <= flt_d;
    out_res_q <= out_res_d; out_flt_q <= out_flt_d;
    if (old_we) old_q[k_q] <= old_d;
    if (new_we) new_q[k_q] <= new_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nrm_q     <= 1'b0;
      dcnt_q    <= '0;
      mstep_q   <= '0;
      smax_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < TOPICS; i++) tt_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      nrm_q     <= nrm_d;
      dcnt_q    <= dcnt_d;
      mstep_q   <= mstep_d;
      smax_q    <= smax_d;
      out_vld_q <= out_vld_d;
      if (tt_we) tt_q[k_q] <= tt_d;
    end
  end

endmodule
